@@ hw/rtl/ptd_pkg.sv @@
// ---------------------------------------------------------------------------
// Period tone detector package
// Shared types and constants for the period tone detector blocks.
// ---------------------------------------------------------------------------
package ptd_pkg;

	localparam int unsigned FREQ_W   = 16;
	localparam int unsigned PERIOD_W = 16;
	localparam int unsigned PCT_W    = 7;
	localparam int unsigned CLK_W    = 24;
	localparam int unsigned PROD_W   = FREQ_W + PCT_W;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = CLK_W;

	localparam logic [FREQ_W-1:0] FREQ_SAT = '1;

	// floor(p / 200) = (p * ceil(2^30 / 100)) >> 31, exact for p below 2^23.
	localparam logic [CLK_W-1:0] RECIP_100   = 24'd10737419;
	localparam int unsigned      RECIP_SHIFT = 31;
	localparam int unsigned      SCALED_W    = PROD_W + CLK_W;

	// Register indexes of the configuration port.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TARGET_FREQ = 2'd0,
		REG_BAND_PCT    = 2'd1,
		REG_FLOOR_FREQ  = 2'd2,
		REG_CLOCK_RATE  = 2'd3
	} ptd_reg_t;

	localparam logic [FREQ_W-1:0] TARGET_RST     = 16'd1000;
	localparam logic [PCT_W-1:0]  BAND_PCT_RST   = 7'd10;
	localparam logic [FREQ_W-1:0] FLOOR_FREQ_RST = 16'd100;
	localparam logic [CLK_W-1:0]  CLK_RATE_RST   = 24'd2000000;

	localparam int unsigned DIV_STEPS = CLK_W;
	localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

	// One classified edge, as it travels from the front end to the back end.
	typedef struct packed {
		logic [PERIOD_W-1:0] period;
		logic                zero;
	} ptd_item_t;

	// Queue status seen by the back end.
	typedef struct packed {
		logic      not_empty;
		ptd_item_t head;
	} ptd_q_status_t;

	typedef struct packed {
		logic [FREQ_W-1:0] target;
		logic [PCT_W-1:0]  pct;
		logic [FREQ_W-1:0] floor_freq;
		logic [CLK_W-1:0]  clk_rate;
	} ptd_cfg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_DONE
	} ptd_state_t;

endpackage

@@ hw/rtl/ptd_front.sv @@
// ---------------------------------------------------------------------------
// Period tone detector front end
// Accepts capture times, forms the wrapped period and pushes it to the queue.
// ---------------------------------------------------------------------------
module ptd_front import ptd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [PERIOD_W-1:0] capture_time,
	input  logic                q_full,
	output logic                push,
	output ptd_item_t           push_item
);

	logic [PERIOD_W-1:0] last_capture_q;

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	always_comb begin
		push_item.period = capture_time - last_capture_q;
		push_item.zero   = (capture_time == last_capture_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_capture_q <= '0;
		end else if (push) begin
			last_capture_q <= capture_time;
		end
	end

endmodule

@@ hw/rtl/ptd_queue.sv @@
// ---------------------------------------------------------------------------
// Period tone detector queue
// Two-entry queue between the front end and the divider back end.
// ---------------------------------------------------------------------------
module ptd_queue import ptd_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  ptd_item_t     push_item,
	output logic          full,
	input  logic          pop,
	output ptd_q_status_t status
);

	ptd_item_t  mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full             = (count_q == 2'd2);
	assign status.not_empty = (count_q != 2'd0);
	assign status.head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ hw/rtl/ptd_back.sv @@
// ---------------------------------------------------------------------------
// Period tone detector back end
// Bit-serial frequency divider, band limits and the result register.
// ---------------------------------------------------------------------------
module ptd_back import ptd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  ptd_cfg_t            cfg,
	input  ptd_q_status_t       q_status,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                tone_detected,
	output logic [FREQ_W-1:0]   measured_freq,
	output logic [PERIOD_W-1:0] period_ticks
);

	ptd_state_t state_q, state_d;

	logic [CNT_W-1:0]    cnt_q;
	logic [CLK_W-1:0]    dq_q;       // dividend shifting out, quotient shifting in
	logic [PERIOD_W-1:0] rem_q;
	logic [PERIOD_W-1:0] divisor_q;
	logic                zero_q;
	logic [PROD_W-1:0]   prod_q;
	logic [SCALED_W-1:0] scaled_q;
	logic [FREQ_W-1:0]   lo_q;
	logic [FREQ_W-1:0]   hi_q;
	logic                out_valid_q;

	logic [PERIOD_W:0]   rem_shift;
	logic                rem_ge;
	logic [FREQ_W-1:0]   half;
	logic [FREQ_W:0]     hi_wide;
	logic [FREQ_W-1:0]   freq;
	logic                hit;
	logic                load_out;

	assign out_valid = out_valid_q;

	always_comb begin
		rem_shift = {rem_q, dq_q[CLK_W-1]};
		rem_ge    = (rem_shift >= {1'b0, divisor_q});
		half      = scaled_q[RECIP_SHIFT +: FREQ_W];
		hi_wide   = {1'b0, cfg.target} + {1'b0, half};
		if (zero_q) begin
			freq = '0;
		end else if (dq_q[CLK_W-1:FREQ_W] != '0) begin
			freq = FREQ_SAT;
		end else begin
			freq = dq_q[FREQ_W-1:0];
		end
		hit = (freq >= cfg.floor_freq) && (freq >= lo_q) && (freq <= hi_q);
	end

	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (q_status.not_empty) begin
					pop     = 1'b1;
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				cnt_q <= '0;
			end else if (state_q == ST_DIV) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			dq_q      <= cfg.clk_rate;
			rem_q     <= '0;
			divisor_q <= q_status.head.period;
			zero_q    <= q_status.head.zero;
		end else if (state_q == ST_DIV) begin
			if (rem_ge) begin
				rem_q <= PERIOD_W'(rem_shift - {1'b0, divisor_q});
			end else begin
				rem_q <= rem_shift[PERIOD_W-1:0];
			end
			dq_q <= {dq_q[CLK_W-2:0], rem_ge};
			// Band limits are worked out in the first few divider steps.
			case (cnt_q)
				CNT_W'(0): prod_q   <= PROD_W'(cfg.target) * PROD_W'(cfg.pct);
				CNT_W'(1): scaled_q <= SCALED_W'(prod_q) * SCALED_W'(RECIP_100);
				CNT_W'(2): begin
					lo_q <= (half > cfg.target) ? '0 : cfg.target - half;
					hi_q <= hi_wide[FREQ_W] ? FREQ_SAT : hi_wide[FREQ_W-1:0];
				end
				default: ;
			endcase
		end
		// The divisor is the period and stays put until the next pop, so the
		// whole result is loaded together and held under out_stall.
		if (load_out) begin
			tone_detected <= hit;
			measured_freq <= freq;
			period_ticks  <= divisor_q;
		end
	end

	a_pop_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (state_q == ST_IDLE && q_status.not_empty))
		else $error("pop outside idle or from an empty queue");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> (!out_valid_q || !out_stall))
		else $error("result register overwritten while held");

	a_zero_freq: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && zero_q) |=> (measured_freq == '0))
		else $error("zero period gave a non-zero frequency");

	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (cnt_q <= CNT_W'(DIV_STEPS - 1)))
		else $error("divider step count overran");

endmodule

@@ hw/rtl/period_tone_detector.sv @@
// ---------------------------------------------------------------------------
// Period tone detector
// Measures the period between rising-edge timestamps, converts it to a
// frequency and flags whether that frequency lies inside a configured band.
// ---------------------------------------------------------------------------
//
//  Channel   Handshake              Payload
//  --------  ---------------------  ------------------------------------------
//  input     in_valid / in_stall    capture_time[15:0]
//  output    out_valid / out_stall  tone_detected, measured_freq, period_ticks
//  config    cfg_we                 cfg_index[1:0], cfg_data[23:0]
//
// In the back end each request leaves the queue, passes through the 24 steps
// of the bit-serial restoring divider (one quotient bit per cycle of the
// 24-bit clock rate) and is then loaded into the result register.
// The front end takes a request in any cycle while the two-entry queue has
// room, so up to two requests can wait while the divider is busy.
// The output register holds a finished result under out_stall; the back end
// then waits with the next request until that result is taken.
// Reset is asynchronous and active low; it restores the default registers
// and clears the stored capture time to zero.
//
module period_tone_detector import ptd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [PERIOD_W-1:0]   capture_time,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  tone_detected,
	output logic [FREQ_W-1:0]     measured_freq,
	output logic [PERIOD_W-1:0]   period_ticks,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// Configuration registers: write only while no request is in flight
	// (not enforced), so the back end may read them directly in its divide.
	ptd_cfg_t cfg_q;

	logic          q_full;
	logic          push;
	logic          pop;
	ptd_item_t     push_item;
	ptd_q_status_t q_status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target     <= TARGET_RST;
			cfg_q.pct        <= BAND_PCT_RST;
			cfg_q.floor_freq <= FLOOR_FREQ_RST;
			cfg_q.clk_rate   <= CLK_RATE_RST;
		end else if (cfg_we) begin
			unique case (ptd_reg_t'(cfg_index))
				REG_TARGET_FREQ: cfg_q.target     <= cfg_data[FREQ_W-1:0];
				REG_BAND_PCT:    cfg_q.pct        <= cfg_data[PCT_W-1:0];
				REG_FLOOR_FREQ:  cfg_q.floor_freq <= cfg_data[FREQ_W-1:0];
				REG_CLOCK_RATE:  cfg_q.clk_rate   <= cfg_data[CLK_W-1:0];
				default: ;
			endcase
		end
	end

	// Front end: takes each request and forms the wrapped period.
	ptd_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.capture_time (capture_time),
		.q_full       (q_full),
		.push         (push),
		.push_item    (push_item)
	);

	// Short queue so that the front end keeps taking requests while the
	// divider works on an earlier one.
	ptd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.status    (q_status)
	);

	// Back end: divider, band check and result register.
	ptd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.q_status      (q_status),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.tone_detected (tone_detected),
		.measured_freq (measured_freq),
		.period_ticks  (period_ticks)
	);

endmodule
